// ===== sv/atfs_pkg.sv =====
// shared types and constants for the ata task-file sector setup block
`default_nettype none

package atfs_pkg;

    // default of the sector address width
    localparam int SECTOR_BITS_DEF = 32;

    // fixed field widths
    localparam int SECTOR_W = 32;
    localparam int CNT_W    = 8;
    localparam int OFF_W    = 3;
    localparam int VAL_W    = 8;
    localparam int SPT_W    = 8;
    localparam int HEADS_W  = 5;
    localparam int HEAD_W   = 4;
    localparam int LBA_W    = 28;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    // heads times sectors per track fits in 13 bits
    localparam int GEO_W    = HEADS_W + SPT_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_USE_LBA      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SELECT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPT          = 2'd3;

    // task-file register offsets
    localparam logic [OFF_W-1:0] OFF_NONE    = 3'd0;
    localparam logic [OFF_W-1:0] OFF_COUNT   = 3'd2;
    localparam logic [OFF_W-1:0] OFF_ADDR0   = 3'd3;
    localparam logic [OFF_W-1:0] OFF_ADDR1   = 3'd4;
    localparam logic [OFF_W-1:0] OFF_ADDR2   = 3'd5;
    localparam logic [OFF_W-1:0] OFF_DRVHEAD = 3'd6;

    // write sequence steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_DRVHEAD = 3'd0;
    localparam logic [STEP_W-1:0] STEP_COUNT   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_ADDR0   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_ADDR1   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_ADDR2   = 3'd4;

    typedef struct packed {
        logic [SECTOR_W-1:0] first_sector;
        logic [CNT_W-1:0]    sector_total;
    } setup_item_t;

    typedef struct packed {
        logic [OFF_W-1:0] reg_offset;
        logic [VAL_W-1:0] reg_value;
        logic             geometry_error;
        logic             last_write;
    } wr_item_t;

    // configuration view handed to the write sequencer
    typedef struct packed {
        logic use_lba;
        logic drive_select;
        logic geo_zero;
    } cfg_view_t;

    // result of the divider chains for one item
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [LBA_W-1:0]  quot;
        logic [HEAD_W-1:0] head;
        logic [SPT_W-1:0]  sect_rem;
    } pipe_item_t;

endpackage

`default_nettype wire

// ===== sv/atfs_stream_if.sv =====
// valid/ready stream interface carrying one item payload
`default_nettype none

interface atfs_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/ata_task_file_sector_setup.sv =====
// top level of the ata task-file sector setup block
// path: an accepted item passes through SECTOR_BITS cells of the cylinder divider,
// then 13 cells of the head divider, then the sequencer, before its first write
// throughput: five writes per item, one item per cycle for a zero-geometry item,
// while the receiver is ready; set by the single write port of the output channel
// reset: rst_n clears all valid bits and the sequencer at once; config returns to
// lba mode, drive 0, 16 heads, 63 sectors per track
`default_nettype none

module ata_task_file_sector_setup #(
    parameter int SECTOR_BITS = atfs_pkg::SECTOR_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [atfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [atfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    atfs_stream_if.sink                            setup,
    atfs_stream_if.source                          task_wr
);
    import atfs_pkg::*;

    localparam int SIDE2_W = CNT_W + LBA_W;

    // configuration registers
    logic               use_lba_reg;
    logic               drive_select_reg;
    logic [HEADS_W-1:0] heads_reg;
    logic [SPT_W-1:0]   spt_reg;

    // divisors: heads times sectors per track for the cylinder, then sectors
    // per track for the head; in lba mode both are one so the sector passes
    // through the first chain unchanged as its quotient
    logic [GEO_W-1:0]   geo_prod;
    logic [GEO_W-1:0]   div1;
    logic [SPT_W-1:0]   div2;

    logic                   adv;
    logic                   take;

    // cylinder chain
    logic                   c1_valid;
    logic [GEO_W-1:0]       c1_rem;
    logic [SECTOR_BITS-1:0] c1_quot;
    logic [CNT_W-1:0]       c1_side;

    // head / sector chain
    logic                   c2_valid;
    logic [SPT_W-1:0]       c2_rem;
    logic [GEO_W-1:0]       c2_quot;
    logic [SIDE2_W-1:0]     c2_side;

    pipe_item_t             pipe_item;
    cfg_view_t              cfg_view;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_lba_reg      <= 1'b1;
            drive_select_reg <= 1'b0;
            heads_reg        <= HEADS_W'(16);
            spt_reg          <= SPT_W'(63);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_USE_LBA:      use_lba_reg      <= cfg_wdata[0];
                CFG_DRIVE_SELECT: drive_select_reg <= cfg_wdata[0];
                CFG_HEADS:        heads_reg        <= cfg_wdata[HEADS_W-1:0];
                CFG_SPT:          spt_reg          <= cfg_wdata[SPT_W-1:0];
                default:          ;
            endcase
        end
    end

    // small 5x8 product from quasi-static registers
    assign geo_prod = GEO_W'(heads_reg) * GEO_W'(spt_reg);
    assign div1     = use_lba_reg ? GEO_W'(1) : geo_prod;
    assign div2     = use_lba_reg ? SPT_W'(1) : spt_reg;

    // whole row moves together; it stalls only while the last cell holds an
    // item the sequencer cannot take yet
    assign adv          = !c2_valid || take;
    assign setup.ready  = adv;

    atfs_div_chain #(
        .NW (SECTOR_BITS),
        .DW (GEO_W),
        .SW (CNT_W)
    ) u_cyl_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .divisor   (div1),
        .in_valid  (setup.valid),
        .in_num    (setup.data.first_sector[SECTOR_BITS-1:0]),
        .in_side   (setup.data.sector_total),
        .out_valid (c1_valid),
        .out_rem   (c1_rem),
        .out_quot  (c1_quot),
        .out_side  (c1_side)
    );

    // second chain divides the remainder; count and quotient ride along
    atfs_div_chain #(
        .NW (GEO_W),
        .DW (SPT_W),
        .SW (SIDE2_W)
    ) u_head_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .divisor   (div2),
        .in_valid  (c1_valid),
        .in_num    (c1_rem),
        .in_side   ({c1_side, c1_quot[LBA_W-1:0]}),
        .out_valid (c2_valid),
        .out_rem   (c2_rem),
        .out_quot  (c2_quot),
        .out_side  (c2_side)
    );

    always_comb
    begin
        pipe_item.count    = c2_side[SIDE2_W-1 -: CNT_W];
        pipe_item.quot     = c2_side[LBA_W-1:0];
        // head is cut to its low four bits
        pipe_item.head     = c2_quot[HEAD_W-1:0];
        pipe_item.sect_rem = c2_rem;

        cfg_view.use_lba      = use_lba_reg;
        cfg_view.drive_select = drive_select_reg;
        cfg_view.geo_zero     = (heads_reg == '0) || (spt_reg == '0);
    end

    atfs_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_view),
        .pipe_valid (c2_valid),
        .pipe_item  (pipe_item),
        .take       (take),
        .task_wr    (task_wr)
    );
endmodule

`default_nettype wire

// ===== sv/atfs_div_cell.sv =====
// one restoring-division cell: one quotient bit per stage
`default_nettype none

module atfs_div_cell #(
    parameter int NW = 32,
    parameter int DW = 13,
    parameter int SW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic [DW-1:0] divisor,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] in_rem,
    input  wire logic [NW-1:0] in_num,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [DW-1:0]      out_rem,
    output logic [NW-1:0]      out_num,
    output logic [SW-1:0]      out_side
);
    logic          valid_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] num_reg;
    logic [SW-1:0] side_reg;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] num_next;

    // shift in next dividend bit, subtract when it fits
    always_comb
    begin
        trial    = {in_rem, in_num[NW-1]};
        diff     = trial - {1'b0, divisor};
        ge       = (trial >= {1'b0, divisor});
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        // dividend shifts out the top, quotient bit enters the bottom
        num_next = {in_num[NW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= rem_next;
            num_reg  <= num_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_side  = side_reg;
endmodule

`default_nettype wire

// ===== sv/atfs_div_chain.sv =====
// row of division cells, one per dividend bit
`default_nettype none

module atfs_div_chain #(
    parameter int NW = 32,
    parameter int DW = 13,
    parameter int SW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic [DW-1:0] divisor,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] in_num,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [DW-1:0]      out_rem,
    output logic [NW-1:0]      out_quot,
    output logic [SW-1:0]      out_side
);
    logic [NW:0]   v;
    logic [DW-1:0] r [NW+1];
    logic [NW-1:0] n [NW+1];
    logic [SW-1:0] s [NW+1];

    assign v[0] = in_valid;
    assign r[0] = '0;
    assign n[0] = in_num;
    assign s[0] = in_side;

    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        atfs_div_cell #(
            .NW (NW),
            .DW (DW),
            .SW (SW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .divisor   (divisor),
            .in_valid  (v[i]),
            .in_rem    (r[i]),
            .in_num    (n[i]),
            .in_side   (s[i]),
            .out_valid (v[i+1]),
            .out_rem   (r[i+1]),
            .out_num   (n[i+1]),
            .out_side  (s[i+1])
        );
    end

    assign out_valid = v[NW];
    assign out_rem   = r[NW];
    assign out_quot  = n[NW];
    assign out_side  = s[NW];
endmodule

`default_nettype wire

// ===== sv/atfs_emitter.sv =====
// write sequencer: turns one divided item into the task-file writes
`default_nettype none

module atfs_emitter (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire atfs_pkg::cfg_view_t    cfg,
    input  wire logic                   pipe_valid,
    input  wire atfs_pkg::pipe_item_t   pipe_item,
    output logic                        take,
    atfs_stream_if.source               task_wr
);
    import atfs_pkg::*;

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic              err_reg;
    logic [VAL_W-1:0]  dh_reg;
    logic [VAL_W-1:0]  cnt_reg;
    logic [VAL_W-1:0]  a0_reg;
    logic [VAL_W-1:0]  a1_reg;
    logic [VAL_W-1:0]  a2_reg;

    logic              last_now;
    logic              fire;
    logic              load;
    logic [HEAD_W-1:0] dh_low;
    wr_item_t          wr;

    always_comb
    begin
        last_now = err_reg || (step_reg == STEP_ADDR2);
        fire     = busy_reg && task_wr.ready;
        // next item loads as soon as the last write of this one goes out
        load     = pipe_valid && (!busy_reg || (fire && last_now));
        take     = load;
        dh_low   = cfg.use_lba ? pipe_item.quot[LBA_W-1 -: HEAD_W] : pipe_item.head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_DRVHEAD;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_DRVHEAD;
            end
            else if (fire)
            begin
                if (last_now)
                begin
                    busy_reg <= 1'b0;
                    step_reg <= STEP_DRVHEAD;
                end
                else
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_reg <= cfg.geo_zero && !cfg.use_lba;
            dh_reg  <= {1'b1, cfg.use_lba, 1'b1, cfg.drive_select, dh_low};
            cnt_reg <= pipe_item.count;
            if (cfg.use_lba)
            begin
                a0_reg <= pipe_item.quot[7:0];
                a1_reg <= pipe_item.quot[15:8];
                a2_reg <= pipe_item.quot[23:16];
            end
            else
            begin
                // 1-based sector, then cylinder low and high bytes
                a0_reg <= pipe_item.sect_rem + VAL_W'(1);
                a1_reg <= pipe_item.quot[7:0];
                a2_reg <= pipe_item.quot[15:8];
            end
        end
    end

    always_comb
    begin
        wr.geometry_error = 1'b0;
        wr.last_write     = 1'b0;
        case (step_reg)
            STEP_DRVHEAD:
            begin
                wr.reg_offset = OFF_DRVHEAD;
                wr.reg_value  = dh_reg;
            end
            STEP_COUNT:
            begin
                wr.reg_offset = OFF_COUNT;
                wr.reg_value  = cnt_reg;
            end
            STEP_ADDR0:
            begin
                wr.reg_offset = OFF_ADDR0;
                wr.reg_value  = a0_reg;
            end
            STEP_ADDR1:
            begin
                wr.reg_offset = OFF_ADDR1;
                wr.reg_value  = a1_reg;
            end
            STEP_ADDR2:
            begin
                wr.reg_offset = OFF_ADDR2;
                wr.reg_value  = a2_reg;
                wr.last_write = 1'b1;
            end
            default:
            begin
                wr.reg_offset = OFF_NONE;
                wr.reg_value  = '0;
            end
        endcase
        // zero geometry: one flagged write only
        if (err_reg)
        begin
            wr.reg_offset     = OFF_NONE;
            wr.reg_value      = '0;
            wr.geometry_error = 1'b1;
            wr.last_write     = 1'b1;
        end
    end

    assign task_wr.valid = busy_reg;
    assign task_wr.data  = wr;
endmodule

`default_nettype wire

// ===== sv/atfs_checker.sv =====
// port-level checks of the task-file write sequence, bound to the top level
`default_nettype none

module atfs_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          wr_valid,
    input wire logic                          wr_ready,
    input wire logic [atfs_pkg::OFF_W-1:0]    wr_offset,
    input wire logic                          wr_error,
    input wire logic                          wr_last
);
    import atfs_pkg::*;

    logic wr_fire;
    assign wr_fire = wr_valid && wr_ready;

    // a write waiting on the sink stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !wr_ready |=> wr_valid)
        else $error("write dropped while stalled");

    // a flagged item is a single last write at offset zero
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && wr_error |-> wr_last && (wr_offset == OFF_NONE))
        else $error("geometry error item not a single write");

    // drive/head is followed at once by the count write
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        wr_fire && (wr_offset == OFF_DRVHEAD) |=> wr_valid && (wr_offset == OFF_COUNT))
        else $error("count write does not follow drive/head");

    // the sequence ends on the high address byte
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !wr_error |-> (wr_last == (wr_offset == OFF_ADDR2)))
        else $error("last write flag misplaced");

    // a write that is not last is followed by more of the same item
    a_cont: assert property (@(posedge clk) disable iff (!rst_n)
        wr_fire && !wr_last |=> wr_valid)
        else $error("write sequence cut short");
endmodule

bind ata_task_file_sector_setup atfs_checker u_atfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_valid  (task_wr.valid),
    .wr_ready  (task_wr.ready),
    .wr_offset (task_wr.data.reg_offset),
    .wr_error  (task_wr.data.geometry_error),
    .wr_last   (task_wr.data.last_write)
);

`default_nettype wire

// ===== bench/atfs_write_checker.sv =====
// checker that predicts and compares the task-file writes of each setup item
`timescale 1ns / 1ps

module atfs_write_checker #(
    parameter int SECTOR_BITS = atfs_pkg::SECTOR_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [atfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [atfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            setup_valid,
    input  logic                            setup_ready,
    input  atfs_pkg::setup_item_t           setup_data,
    input  logic                            wr_valid,
    input  logic                            wr_ready,
    input  atfs_pkg::wr_item_t              wr_data,
    output int                              mismatches,
    output int                              writes_pending
);
    import atfs_pkg::*;

    localparam longint unsigned SECTOR_MASK = (64'd1 << SECTOR_BITS) - 64'd1;
    // bits 7 and 5 of drive/head are always set
    localparam logic [VAL_W-1:0] DRVHEAD_BASE = 8'hA0;

    logic               lba_q;
    logic               drive_q;
    logic [HEADS_W-1:0] heads_q;
    logic [SPT_W-1:0]   spt_q;

    wr_item_t expected_writes[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    function automatic void expect_write(input logic [OFF_W-1:0] off,
                                         input logic [VAL_W-1:0] val,
                                         input logic err, input logic last);
        wr_item_t w;
        w.reg_offset     = off;
        w.reg_value      = val;
        w.geometry_error = err;
        w.last_write     = last;
        expected_writes.push_back(w);
    endfunction

    function automatic void predict_setup(input setup_item_t req);
        logic [SECTOR_W-1:0] sector;
        logic [SECTOR_W-1:0] geo;
        logic [SECTOR_W-1:0] cyl;
        logic [SECTOR_W-1:0] rem;
        logic [SECTOR_W-1:0] head;
        logic [SECTOR_W-1:0] sect;
        logic [VAL_W-1:0]    drvhead;
        logic [VAL_W-1:0]    addr0;
        logic [VAL_W-1:0]    addr1;
        logic [VAL_W-1:0]    addr2;
        sector     = SECTOR_W'(64'(req.first_sector) & SECTOR_MASK);
        drvhead    = DRVHEAD_BASE;
        drvhead[4] = drive_q;
        if (lba_q)
        begin
            drvhead[6]   = 1'b1;
            drvhead[3:0] = sector[27:24];
            addr0        = sector[7:0];
            addr1        = sector[15:8];
            addr2        = sector[23:16];
        end
        else
        begin
            geo = SECTOR_W'(heads_q) * SECTOR_W'(spt_q);
            if (geo == '0)
            begin
                // zero geometry: one flagged result, no task-file writes
                expect_write(OFF_NONE, '0, 1'b1, 1'b1);
                return;
            end
            cyl          = sector / geo;
            rem          = sector % geo;
            head         = rem / SECTOR_W'(spt_q);
            sect         = rem % SECTOR_W'(spt_q) + SECTOR_W'(1);
            drvhead[3:0] = head[3:0];
            addr0        = sect[7:0];
            addr1        = cyl[7:0];
            addr2        = cyl[15:8];
        end
        expect_write(OFF_DRVHEAD, drvhead, 1'b0, 1'b0);
        expect_write(OFF_COUNT, req.sector_total, 1'b0, 1'b0);
        expect_write(OFF_ADDR0, addr0, 1'b0, 1'b0);
        expect_write(OFF_ADDR1, addr1, 1'b0, 1'b0);
        expect_write(OFF_ADDR2, addr2, 1'b0, 1'b1);
    endfunction

    task automatic check_write(input wr_item_t got);
        wr_item_t want;
        if (expected_writes.size() == 0)
        begin
            report_mismatch("write with none expected", 32'(got), '0);
            return;
        end
        want = expected_writes.pop_front();
        if (got.reg_offset !== want.reg_offset)
            report_mismatch("reg_offset", 32'(got.reg_offset), 32'(want.reg_offset));
        if (got.reg_value !== want.reg_value)
            report_mismatch("reg_value", 32'(got.reg_value), 32'(want.reg_value));
        if (got.geometry_error !== want.geometry_error)
            report_mismatch("geometry_error", 32'(got.geometry_error),
                            32'(want.geometry_error));
        if (got.last_write !== want.last_write)
            report_mismatch("last_write", 32'(got.last_write), 32'(want.last_write));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lba_q   = 1'b1;
            drive_q = 1'b0;
            heads_q = 5'd16;
            spt_q   = 8'd63;
            expected_writes.delete();
            mismatches     = 0;
            writes_pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_USE_LBA:      lba_q   = cfg_wdata[0];
                    CFG_DRIVE_SELECT: drive_q = cfg_wdata[0];
                    CFG_HEADS:        heads_q = cfg_wdata[HEADS_W-1:0];
                    CFG_SPT:          spt_q   = cfg_wdata[SPT_W-1:0];
                    default: ;
                endcase
            end
            if (setup_valid && setup_ready)
                predict_setup(setup_data);
            if (wr_valid && wr_ready)
                check_write(wr_data);
            writes_pending = expected_writes.size();
        end
    end

endmodule

// ===== bench/ata_task_file_sector_setup_tb.sv =====
// testbench top for the ata task-file sector setup block
`timescale 1ns / 1ps

module ata_task_file_sector_setup_tb;
    import atfs_pkg::*;

    localparam int SECTOR_BITS   = 32;
    // divider chains plus sequencer, see the block's header
    localparam int PIPE_CYCLES   = SECTOR_BITS + 14;
    // cycles with no item accepted on either channel before giving up
    localparam int IDLE_LIMIT    = 4000;
    // length of the long receiver hold-off
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 45;
    // items offered back to back while the receiver holds off
    localparam int BURST_ITEMS   = 80;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    atfs_stream_if #(.payload_t(setup_item_t)) setup_ch ();
    atfs_stream_if #(.payload_t(wr_item_t))    wr_ch ();

    int mismatches;
    int writes_pending;

    // request from the stimulus to the receiver for one long hold-off
    logic hold_off_req = 1'b0;
    // items left in the current sender burst
    int   burst_left;
    // geometry as last written, used to aim sectors at cylinder edges
    logic [HEADS_W-1:0] cur_heads;
    logic [SPT_W-1:0]   cur_spt;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ata_task_file_sector_setup #(
        .SECTOR_BITS(SECTOR_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .setup     (setup_ch),
        .task_wr   (wr_ch)
    );

    atfs_write_checker #(
        .SECTOR_BITS(SECTOR_BITS)
    ) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .setup_valid    (setup_ch.valid),
        .setup_ready    (setup_ch.ready),
        .setup_data     (setup_ch.data),
        .wr_valid       (wr_ch.valid),
        .wr_ready       (wr_ch.ready),
        .wr_data        (wr_ch.data),
        .mismatches     (mismatches),
        .writes_pending (writes_pending)
    );

    // write all four registers on consecutive cycles; the unused upper bits
    // of the write data carry junk, the block must mask them off
    task automatic apply_config(input logic lba, input logic drive,
                                input logic [HEADS_W-1:0] heads,
                                input logic [SPT_W-1:0] spt);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_USE_LBA;
        cfg_wdata <= {junk[7:1], lba};
        @(negedge clk);
        junk = CFG_DATA_W'($urandom);
        cfg_index <= CFG_DRIVE_SELECT;
        cfg_wdata <= {junk[7:1], drive};
        @(negedge clk);
        junk = CFG_DATA_W'($urandom);
        cfg_index <= CFG_HEADS;
        cfg_wdata <= {junk[7:5], heads};
        @(negedge clk);
        cfg_index <= CFG_SPT;
        cfg_wdata <= spt;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_heads = heads;
        cur_spt   = spt;
    endtask

    // offer one item, in bursts of random length with random gaps between
    task automatic send_setup(input logic [SECTOR_W-1:0] sector,
                              input logic [CNT_W-1:0] total);
        int gap;
        if (burst_left == 0)
        begin
            // now and then a new burst starts with no gap at all
            if ($urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 12);
                setup_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        setup_ch.valid <= 1'b1;
        setup_ch.data  <= {sector, total};
        do
            @(posedge clk);
        while (setup_ch.ready !== 1'b1);
        @(negedge clk);
        burst_left--;
    endtask

    // stop offering, wait for every expected write, then let the
    // pipeline run dry so a config write cannot hit an item in flight
    task automatic wait_for_idle();
        setup_ch.valid <= 1'b0;
        burst_left = 0;
        while (writes_pending != 0)
            @(negedge clk);
        repeat (PIPE_CYCLES + 20) @(negedge clk);
    endtask

    // sectors: mostly uniform, some small, some right around a cylinder
    // boundary, some at the 28-bit edge and the all-zero/all-one ends
    function automatic logic [SECTOR_W-1:0] pick_sector();
        longint unsigned geo;
        longint unsigned k;
        logic [3:0]      top_bits;
        logic [SECTOR_W-1:0] s;
        geo = 64'(cur_heads) * 64'(cur_spt);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
                s = $urandom;
            5, 6:
                s = $urandom_range(0, 200000);
            7:
            begin
                if (geo == 0)
                    s = $urandom;
                else
                begin
                    k = 64'($urandom) % (64'hFFFF_FFFF / geo + 64'd1);
                    s = SECTOR_W'(k * geo + 64'($urandom_range(0, 2)) - 64'd1);
                end
            end
            8:
            begin
                top_bits = 4'($urandom);
                s = {top_bits, ($urandom_range(0, 1) ? 28'hFFF_FFFF : 28'h000_0000)};
            end
            default:
                s = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        endcase
        return s;
    endfunction

    // a new setting per phase: lba, ordinary chs, chs with too many heads,
    // and zero geometry in either register
    task automatic pick_random_config();
        int                 mode;
        logic               lba;
        logic [HEADS_W-1:0] heads;
        logic [SPT_W-1:0]   spt;
        mode  = $urandom_range(0, 9);
        lba   = (mode < 3);
        heads = HEADS_W'($urandom_range(1, 16));
        spt   = SPT_W'($urandom_range(1, 255));
        if (mode == 0)
        begin
            heads = '0;
            spt   = '0;
        end
        if (mode == 8)
            heads = HEADS_W'($urandom_range(17, 31));
        if (mode == 9)
        begin
            if ($urandom_range(0, 1))
                heads = '0;
            else
                spt = '0;
        end
        apply_config(lba, 1'($urandom_range(0, 1)), heads, spt);
    endtask

    // receiver: stall patterns of its own, plus one long hold-off on request
    initial
    begin
        int          hold_left;
        int          phase_left;
        int          mode;
        logic [15:0] pattern;
        hold_left   = 0;
        phase_left  = 0;
        mode        = 0;
        pattern     = '1;
        wr_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && hold_left == 0)
            begin
                hold_left    = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                wr_ch.ready <= 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    mode       = $urandom_range(0, 3);
                    phase_left = $urandom_range(16, 96);
                    pattern    = 16'($urandom);
                end
                phase_left--;
                case (mode)
                    // no stalls at all
                    0: wr_ch.ready <= 1'b1;
                    // rotating 16-bit pattern
                    1:
                    begin
                        wr_ch.ready <= pattern[0];
                        pattern = {pattern[0], pattern[15:1]};
                    end
                    // mostly ready
                    2: wr_ch.ready <= ($urandom_range(0, 3) != 0);
                    // mostly stalled
                    default: wr_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog: ends the run when nothing moves for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((setup_ch.valid && setup_ch.ready) || (wr_ch.valid && wr_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        setup_ch.valid = 1'b0;
        setup_ch.data  = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_USE_LBA;
        cfg_wdata      = '0;
        rst_n          = 1'b0;
        burst_left     = 0;
        cur_heads      = 5'd16;
        cur_spt        = 8'd63;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, lba: address extremes, 28-bit edge, count extremes
        send_setup(32'h0000_0000, 8'h00);
        send_setup(32'hFFFF_FFFF, 8'hFF);
        send_setup(32'h0FFF_FFFF, 8'h01);
        send_setup(32'h1000_0000, 8'h80);
        send_setup(32'h00FF_FFFF, 8'h7F);
        send_setup(32'h1234_5678, 8'h00);

        // chs 16 x 63: last sector of cylinder 0, first of cylinder 1,
        // and the largest sector with its cylinder cut to 16 bits
        wait_for_idle();
        apply_config(1'b0, 1'b0, 5'd16, 8'd63);
        send_setup(32'd0, 8'h01);
        send_setup(32'd1007, 8'h02);
        send_setup(32'd1008, 8'h03);
        send_setup(32'hFFFF_FFFF, 8'hFF);

        // smallest geometry, slave drive: every sector is its own cylinder
        wait_for_idle();
        apply_config(1'b0, 1'b1, 5'd1, 8'd1);
        send_setup(32'd0, 8'h00);
        send_setup(32'hFFFF_FFFF, 8'h55);

        // zero heads gives the flagged result
        wait_for_idle();
        apply_config(1'b0, 1'b0, 5'd0, 8'd63);
        send_setup(32'd12345, 8'hAA);
        send_setup(32'd0, 8'h00);

        // zero sectors per track gives the flagged result too
        wait_for_idle();
        apply_config(1'b0, 1'b1, 5'd16, 8'd0);
        send_setup(32'hFFFF_FFFF, 8'h01);
        send_setup(32'd7, 8'h02);

        // more heads than fit in four bits: the head is truncated
        wait_for_idle();
        apply_config(1'b0, 1'b0, 5'd31, 8'd255);
        send_setup(32'd7904, 8'h10);
        send_setup(32'hFFFF_FFFF, 8'h20);

        // lba ignores a zero geometry
        wait_for_idle();
        apply_config(1'b1, 1'b1, 5'd0, 8'd0);
        send_setup(32'h0F00_0000, 8'hFF);
        send_setup(32'hFFFF_FFFF, 8'h00);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 3)
            begin
                // receiver holds off while the sender keeps offering with
                // no gaps, so the pipeline fills and input stalls
                wait_for_idle();
                apply_config(1'b0, 1'($urandom_range(0, 1)), 5'd16, 8'd63);
                hold_off_req = 1'b1;
                burst_left   = BURST_ITEMS + 1;
                repeat (BURST_ITEMS) send_setup(pick_sector(), CNT_W'($urandom));
                burst_left = 0;
            end
            wait_for_idle();
            pick_random_config();
            repeat (PHASE_ITEMS) send_setup(pick_sector(), CNT_W'($urandom));
        end

        wait_for_idle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== ata_task_file_sector_setup.f =====
sv/atfs_pkg.sv
sv/atfs_stream_if.sv
sv/atfs_div_cell.sv
sv/atfs_div_chain.sv
sv/atfs_emitter.sv
sv/ata_task_file_sector_setup.sv
sv/atfs_checker.sv
bench/atfs_write_checker.sv
bench/ata_task_file_sector_setup_tb.sv
